FILE: rtl/core/agc_pkg.sv
// ----------------------------------------------------------------------------
// agc_pkg
// Shared types and constants of the sliding-RMS gain control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package agc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 48;
  localparam int DEN_W    = 21;
  localparam int REM_W    = 27;
  localparam int CNT_W    = 6;
  localparam int GAIN_W   = 21;
  localparam int MUL_W    = 24;

  localparam logic OP_DIV  = 1'b0;
  localparam logic OP_SQRT = 1'b1;

  localparam logic [2:0] REG_WINDOW = 3'd0;
  localparam logic [2:0] REG_STEP   = 3'd1;
  localparam logic [2:0] REG_TARGET = 3'd2;
  localparam logic [2:0] REG_MAXG   = 3'd3;
  localparam logic [2:0] REG_DECAY  = 3'd4;

  localparam logic [17:0] WINDOW_RST = 18'd192000;
  localparam logic [23:0] STEP_RST   = 24'd1748;
  localparam logic [14:0] TARGET_RST = 15'd1638;
  localparam logic [20:0] MAXG_RST   = 21'd655360;
  localparam logic [15:0] DECAY_RST  = 16'd65470;
  localparam logic [20:0] UNITY_GAIN = 21'd65536;

  typedef struct packed {
    logic             start;
    logic             op;
    logic [CNT_W-1:0] iters;
  } unit_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

FILE: rtl/core/rms_automatic_gain_control.sv
// The shared divide/root unit produces one quotient bit or root digit a cycle
// (mean 48 bits, root 24 digits, target gain 31 bits, limiter 32 bits when
// taken); a silent window skips the target gain and the limiter.
// One item is handled at a time (in_stall while busy); the next item is taken while
// a result waits, and a stalled result holds the sequencer before it is sent.
// Reset: registers to defaults, slots, sum and peak clear, gain to unity; RAM kept.
// ----------------------------------------------------------------------------
// rms_automatic_gain_control
// Sliding-window RMS automatic gain control with a sequenced shared datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rms_automatic_gain_control #(
  parameter int RING_DEPTH = 262144
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [23:0] wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [15:0] sample_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] sample_out,
  output logic [20:0] gain_now
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int FW = $clog2(RING_DEPTH + 1);
  localparam int WW = (FW > 18) ? FW : 18;
  localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
  localparam logic [WW-1:0] WIN_MAX   = WW'(RING_DEPTH - 1);
  localparam logic [FW-1:0] DEPTH_F   = FW'(RING_DEPTH);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RCHK = 5'd1;
  localparam logic [4:0] S_RRD  = 5'd2;
  localparam logic [4:0] S_RSUB = 5'd3;
  localparam logic [4:0] S_WR   = 5'd4;
  localparam logic [4:0] S_ADD  = 5'd5;
  localparam logic [4:0] S_DIV  = 5'd6;
  localparam logic [4:0] S_SQRT = 5'd7;
  localparam logic [4:0] S_PEAK = 5'd8;
  localparam logic [4:0] S_TGS  = 5'd9;
  localparam logic [4:0] S_TGW  = 5'd10;
  localparam logic [4:0] S_TGM  = 5'd11;
  localparam logic [4:0] S_STEP = 5'd12;
  localparam logic [4:0] S_LIM1 = 5'd13;
  localparam logic [4:0] S_LIM2 = 5'd14;
  localparam logic [4:0] S_LIMW = 5'd15;
  localparam logic [4:0] S_APP  = 5'd16;
  localparam logic [4:0] S_SAT  = 5'd17;
  localparam logic [4:0] S_FIN  = 5'd18;

  logic [4:0]  state;
  logic [17:0] window_length;
  logic [23:0] catch_up_step;
  logic [14:0] target_rms;
  logic [20:0] max_gain;
  logic [15:0] peak_decay;

  logic [AW-1:0]             write_slot;
  logic [AW-1:0]             oldest_slot;
  logic [agc_pkg::SUM_W-1:0] sum_squares;
  logic [15:0]               peak_rms;
  logic [20:0]               gain_reg;

  logic [15:0]   xs;
  logic [15:0]   ax;
  logic [FW-1:0] fill;
  logic [WW-1:0] win;
  logic [1:0]    kret;
  logic [15:0]   rms;
  logic [20:0]   tgain;
  logic          up;
  logic [15:0]   res_y;
  logic [20:0]   res_g;

  logic [2*agc_pkg::MUL_W-1:0] prod;
  logic [agc_pkg::MUL_W-1:0]   mul_a;
  logic [agc_pkg::MUL_W-1:0]   mul_b;

  logic                      ram_we;
  logic [15:0]               ram_rdata;
  logic [15:0]               old_abs;

  agc_pkg::unit_cmd_t        ucmd;
  agc_pkg::unit_stat_t       ustat;
  logic [agc_pkg::SUM_W-1:0] unum;
  logic [agc_pkg::DEN_W-1:0] uden;
  logic [agc_pkg::SUM_W-1:0] uq;

  logic [WW-1:0]             wl_ext;
  logic [agc_pkg::SUM_W-1:0] sum_add;
  logic [FW-1:0]             ws_f;
  logic [FW-1:0]             os_f;
  logic [20:0]               mag;

  assign in_stall = (state != S_IDLE);
  assign ram_we   = (state == S_WR);
  assign old_abs  = ram_rdata[15] ? 16'(-ram_rdata) : ram_rdata;
  assign sum_add  = sum_squares + prod;
  assign wl_ext   = WW'(window_length);
  assign ws_f     = FW'(write_slot);
  assign os_f     = FW'(oldest_slot);
  assign mag      = prod[36:16];

  agc_ram #(
    .WIDTH(16),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(write_slot),
    .wdata(xs),
    .raddr(oldest_slot),
    .rdata(ram_rdata)
  );

  agc_divsqrt u_unit (
    .clk (clk),
    .rst (rst),
    .cmd (ucmd),
    .num (unum),
    .den (uden),
    .stat(ustat),
    .q   (uq)
  );

  // Operand and command selection for the shared multiplier and unit
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    ucmd.start = 1'b0;
    ucmd.op    = agc_pkg::OP_DIV;
    ucmd.iters = agc_pkg::CNT_W'(48);
    unum       = sum_add;
    uden       = agc_pkg::DEN_W'(fill);
    case (state)
      S_RRD: begin
        mul_a = 24'(old_abs);
        mul_b = 24'(old_abs);
      end
      S_WR: begin
        mul_a = 24'(ax);
        mul_b = 24'(ax);
      end
      S_ADD: begin
        ucmd.start = 1'b1;
      end
      S_DIV: begin
        ucmd.start = ustat.done;
        ucmd.op    = agc_pkg::OP_SQRT;
        ucmd.iters = agc_pkg::CNT_W'(24);
        unum       = uq;
      end
      S_SQRT: begin
        mul_a = 24'(peak_rms - uq[15:0]);
        mul_b = 24'(peak_decay);
      end
      S_TGS: begin
        ucmd.start = 1'b1;
        ucmd.iters = agc_pkg::CNT_W'(31);
        unum       = {target_rms, 16'd0, 17'd0};
        uden       = agc_pkg::DEN_W'(peak_rms);
      end
      S_TGM: begin
        mul_a = 24'(up ? tgain - gain_reg : gain_reg - tgain);
        mul_b = catch_up_step;
      end
      S_LIM1, S_APP: begin
        mul_a = 24'(ax);
        mul_b = 24'(gain_reg);
      end
      S_LIM2: begin
        ucmd.start = (prod > 48'h0000_8000_0000);
        ucmd.iters = agc_pkg::CNT_W'(32);
        unum       = {32'h8000_0000, 16'd0};
        uden       = agc_pkg::DEN_W'(ax);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= agc_pkg::WINDOW_RST;
      catch_up_step <= agc_pkg::STEP_RST;
      target_rms    <= agc_pkg::TARGET_RST;
      max_gain      <= agc_pkg::MAXG_RST;
      peak_decay    <= agc_pkg::DECAY_RST;
    end else if (wr_en) begin
      case (wr_index)
        agc_pkg::REG_WINDOW: window_length <= wr_data[17:0];
        agc_pkg::REG_STEP:   catch_up_step <= wr_data[23:0];
        agc_pkg::REG_TARGET: target_rms    <= wr_data[14:0];
        agc_pkg::REG_MAXG:   max_gain      <= wr_data[20:0];
        agc_pkg::REG_DECAY:  peak_decay    <= wr_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      write_slot  <= '0;
      oldest_slot <= '0;
      sum_squares <= '0;
      peak_rms    <= '0;
      gain_reg    <= agc_pkg::UNITY_GAIN;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            xs    <= sample_in;
            ax    <= sample_in[15] ? 16'(-sample_in) : sample_in;
            kret  <= '0;
            fill  <= ((write_slot >= oldest_slot) ? ws_f - os_f
                                                  : ws_f + DEPTH_F - os_f) + 1'b1;
            if (wl_ext == '0) begin
              win <= WW'(1);
            end else if (wl_ext > WIN_MAX) begin
              win <= WIN_MAX;
            end else begin
              win <= wl_ext;
            end
            state <= S_RCHK;
          end
        end
        S_RCHK: begin
          // retire at most two of the oldest items per input
          if (kret != 2'd2 && WW'(fill) > win) begin
            state <= S_RRD;
          end else begin
            state <= S_WR;
          end
        end
        S_RRD: state <= S_RSUB;
        S_RSUB: begin
          sum_squares <= sum_squares - prod;
          oldest_slot <= (oldest_slot == LAST_SLOT) ? '0 : oldest_slot + 1'b1;
          fill        <= fill - 1'b1;
          kret        <= kret + 1'b1;
          state       <= S_RCHK;
        end
        S_WR: begin
          write_slot <= (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
          state      <= S_ADD;
        end
        S_ADD: begin
          sum_squares <= sum_add;
          state       <= S_DIV;
        end
        S_DIV: begin
          if (ustat.done) begin
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (ustat.done) begin
            rms <= uq[15:0];
            if (uq == '0) begin
              // silent window: pass the sample through at unity
              res_y <= xs;
              res_g <= agc_pkg::UNITY_GAIN;
              state <= S_FIN;
            end else if (uq[15:0] >= peak_rms) begin
              peak_rms <= uq[15:0];
              state    <= S_TGS;
            end else begin
              state <= S_PEAK;
            end
          end
        end
        S_PEAK: begin
          peak_rms <= rms + prod[31:16];
          state    <= S_TGS;
        end
        S_TGS: state <= S_TGW;
        S_TGW: begin
          if (ustat.done) begin
            tgain <= (uq[30:0] > 31'(max_gain)) ? max_gain : uq[20:0];
            state <= S_TGM;
          end
        end
        S_TGM: state <= S_STEP;
        S_STEP: begin
          gain_reg <= up ? gain_reg + prod[44:24] : gain_reg - prod[44:24];
          state    <= S_LIM1;
        end
        S_LIM1: state <= S_LIM2;
        S_LIM2: begin
          state <= (prod > 48'h0000_8000_0000) ? S_LIMW : S_APP;
        end
        S_LIMW: begin
          if (ustat.done) begin
            gain_reg <= uq[20:0];
            state    <= S_APP;
          end
        end
        S_APP: state <= S_SAT;
        S_SAT: begin
          res_g <= gain_reg;
          if (xs[15]) begin
            res_y <= (mag > 21'd32768) ? 16'h8000 : 16'(-mag);
          end else begin
            res_y <= (mag > 21'd32767) ? 16'h7FFF : mag[15:0];
          end
          state <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            sample_out <= res_y;
            gain_now   <= res_g;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_TGW && ustat.done) begin
      up <= (((uq[30:0] > 31'(max_gain)) ? max_gain : uq[20:0]) >= gain_reg);
    end
  end

  a_unit_start_idle : assert property (@(posedge clk) disable iff (rst)
    ucmd.start |-> !ustat.busy)
    else $error("shared unit started while busy");

  a_slots_range : assert property (@(posedge clk) disable iff (rst)
    (write_slot <= LAST_SLOT) && (oldest_slot <= LAST_SLOT))
    else $error("ring slot out of range");

  a_done_expected : assert property (@(posedge clk) disable iff (rst)
    ustat.done |-> (state == S_DIV || state == S_SQRT || state == S_TGW
                    || state == S_LIMW))
    else $error("unit result arrived in an unexpected state");

  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> (fill != '0))
    else $error("fill count reached zero");

endmodule

FILE: rtl/core/agc_ram.sv
// ----------------------------------------------------------------------------
// agc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module agc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/agc_divsqrt.sv
// ----------------------------------------------------------------------------
// agc_divsqrt
// Shared restoring divider and digit-by-digit square root, one step a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module agc_divsqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  agc_pkg::unit_cmd_t                cmd,
  input  logic [agc_pkg::SUM_W-1:0]         num,
  input  logic [agc_pkg::DEN_W-1:0]         den,
  output agc_pkg::unit_stat_t               stat,
  output logic [agc_pkg::SUM_W-1:0]         q
);

  logic                            busy;
  logic                            done;
  logic                            op;
  logic [agc_pkg::CNT_W-1:0]       cnt;
  logic [agc_pkg::SUM_W-1:0]       nr;
  logic [agc_pkg::REM_W-1:0]       rem;
  logic [agc_pkg::DEN_W-1:0]       den_r;
  logic [agc_pkg::REM_W-1:0]       rem_sh;
  logic [agc_pkg::REM_W-1:0]       trial;
  logic                            ge;

  always_comb begin
    if (op == agc_pkg::OP_SQRT) begin
      rem_sh = {rem[agc_pkg::REM_W-3:0], nr[agc_pkg::SUM_W-1 -: 2]};
      trial  = {q[agc_pkg::REM_W-3:0], 2'b01};
    end else begin
      rem_sh = {rem[agc_pkg::REM_W-2:0], nr[agc_pkg::SUM_W-1]};
      trial  = agc_pkg::REM_W'(den_r);
    end
    ge = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start && !busy) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start && !busy) begin
      op    <= cmd.op;
      cnt   <= cmd.iters - 1'b1;
      nr    <= num;
      den_r <= den;
      rem   <= '0;
      q     <= '0;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      rem <= ge ? rem_sh - trial : rem_sh;
      q   <= {q[agc_pkg::SUM_W-2:0], ge};
      nr  <= (op == agc_pkg::OP_SQRT) ? {nr[agc_pkg::SUM_W-3:0], 2'b00}
                                      : {nr[agc_pkg::SUM_W-2:0], 1'b0};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
